// File: rtl/i2cmt_pkg.sv
// Shared types and constants for the I2C master transaction block.
// Used by i2cmt_core and i2c_master_transaction. No dependencies.
`timescale 1ns / 1ps

package i2cmt_pkg;

  localparam int LENGTH_BITS = 8;

  // phase codes
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START    = 4'd1;
  localparam logic [3:0] PH_ADDR     = 4'd2;
  localparam logic [3:0] PH_ADDR_ACK = 4'd3;
  localparam logic [3:0] PH_WDATA    = 4'd4;
  localparam logic [3:0] PH_WACK     = 4'd5;
  localparam logic [3:0] PH_RDATA    = 4'd6;
  localparam logic [3:0] PH_RACK     = 4'd7;
  localparam logic [3:0] PH_STOP     = 4'd8;

  // command codes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // completion codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ADDR = 2'd1;
  localparam logic [1:0] ERR_DATA = 2'd2;

  // register map
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd72;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] transfer_length;
    logic [7:0] write_byte;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       byte_request;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic [1:0] error_code;
  } result_t;

  typedef struct packed {
    logic [3:0]             phase;
    logic [1:0]             tick_in_bit;
    logic [2:0]             bit_index;
    logic [7:0]             shift_byte;
    logic [LENGTH_BITS-1:0] bytes_left;
    logic                   is_read;
    logic [1:0]             pending_error;
  } state_t;

endpackage

// File: rtl/i2cmt_core.sv
// Per-tick bus sequencer: next controller state and line levels for one tick.
// Pure combinational; depends on i2cmt_pkg.
`timescale 1ns / 1ps

module i2cmt_core import i2cmt_pkg::*; (
  input  logic [6:0] device_address,
  input  tick_t      tick,
  input  state_t     state,
  output state_t     state_next,
  output result_t    result
);

  logic [LENGTH_BITS-1:0] len;
  logic                   last_tick;
  logic                   scl;
  logic                   sda;
  logic                   req;
  logic                   rvalid;
  logic [7:0]             rbyte;
  logic                   done;
  state_t                 s;

  always_comb begin
    s = state;
    scl = 1'b1;
    sda = 1'b1;
    req = 1'b0;
    rvalid = 1'b0;
    rbyte = 8'd0;
    done = 1'b0;
    len = LENGTH_BITS'(tick.transfer_length);

    // command taken only while idle
    if (s.phase == PH_IDLE && (tick.mode inside {MODE_WRITE, MODE_READ})) begin
      s.is_read = (tick.mode == MODE_READ);
      if (s.is_read && len == '0) begin
        len = LENGTH_BITS'(1);
      end
      s.bytes_left = len;
      s.pending_error = ERR_NONE;
      s.tick_in_bit = 2'd0;
      s.bit_index = 3'd0;
      s.phase = PH_START;
    end

    last_tick = (s.tick_in_bit == 2'd3);

    case (s.phase)
      PH_START: begin
        scl = (s.tick_in_bit < 2'd2);
        sda = (s.tick_in_bit == 2'd0);
        if (last_tick) begin
          s.shift_byte = {device_address, s.is_read};
          s.bit_index = 3'd0;
          s.phase = PH_ADDR;
        end
      end
      PH_ADDR, PH_WDATA: begin
        // load the next data byte on the first tick of its first bit
        if (s.phase == PH_WDATA && s.bit_index == 3'd0 && s.tick_in_bit == 2'd0) begin
          s.shift_byte = tick.write_byte;
          req = 1'b1;
        end
        scl = (s.tick_in_bit == 2'd1);
        sda = s.shift_byte[~s.bit_index];
        if (last_tick) begin
          if (s.bit_index == 3'd7) begin
            s.bit_index = 3'd0;
            s.phase = (s.phase == PH_ADDR) ? PH_ADDR_ACK : PH_WACK;
          end else begin
            s.bit_index = s.bit_index + 3'd1;
          end
        end
      end
      PH_ADDR_ACK, PH_WACK: begin
        scl = (s.tick_in_bit == 2'd1);
        if (s.tick_in_bit == 2'd1 && tick.sda_in) begin
          s.pending_error = (s.phase == PH_ADDR_ACK) ? ERR_ADDR : ERR_DATA;
        end
        if (last_tick) begin
          if (s.pending_error != ERR_NONE) begin
            s.phase = PH_STOP;
          end else if (s.phase == PH_ADDR_ACK) begin
            if (s.is_read) begin
              s.phase = PH_RDATA;
            end else begin
              s.phase = (s.bytes_left == '0) ? PH_STOP : PH_WDATA;
            end
          end else begin
            s.bytes_left = s.bytes_left - LENGTH_BITS'(1);
            s.phase = (s.bytes_left == '0) ? PH_STOP : PH_WDATA;
          end
          s.bit_index = 3'd0;
        end
      end
      PH_RDATA: begin
        scl = (s.tick_in_bit == 2'd1);
        // sample while scl is high
        if (s.tick_in_bit == 2'd1) begin
          s.shift_byte = {s.shift_byte[6:0], tick.sda_in};
        end
        if (last_tick) begin
          if (s.bit_index == 3'd7) begin
            rbyte = s.shift_byte;
            rvalid = 1'b1;
            s.bit_index = 3'd0;
            s.phase = PH_RACK;
          end else begin
            s.bit_index = s.bit_index + 3'd1;
          end
        end
      end
      PH_RACK: begin
        scl = (s.tick_in_bit == 2'd1);
        // ack every byte but the last
        sda = !(s.bytes_left > LENGTH_BITS'(1));
        if (last_tick) begin
          if (s.bytes_left != '0) begin
            s.bytes_left = s.bytes_left - LENGTH_BITS'(1);
          end
          s.phase = (s.bytes_left == '0) ? PH_STOP : PH_RDATA;
          s.bit_index = 3'd0;
        end
      end
      PH_STOP: begin
        scl = (s.tick_in_bit != 2'd0);
        sda = (s.tick_in_bit >= 2'd2);
        if (last_tick) begin
          done = 1'b1;
          s.phase = PH_IDLE;
          s.bit_index = 3'd0;
        end
      end
      default: begin
        s.phase = PH_IDLE;
      end
    endcase

    if (s.phase == PH_IDLE && !done) begin
      s.tick_in_bit = 2'd0;
    end else begin
      s.tick_in_bit = s.tick_in_bit + 2'd1;
    end

    state_next = s;

    result.scl_level = scl;
    result.sda_level = sda;
    result.byte_request = req;
    result.read_byte = rbyte;
    result.read_valid = rvalid;
    result.busy_res = (s.phase != PH_IDLE) || done;
    result.done_res = done;
    result.error_code = done ? s.pending_error : ERR_NONE;
  end

endmodule

// File: rtl/i2c_master_transaction.sv
// Top level of the I2C master transaction block: APB register, state and result registers.
// Depends on i2cmt_pkg and i2cmt_core.
`timescale 1ns / 1ps

// Usage
// Each beat on the tick channel is one bus timing tick: it carries a command
// (tick only, begin write, begin read), the transfer length, the next write
// byte and the sampled SDA level. Each accepted tick gives exactly one beat on
// the result channel with the SCL and SDA drive levels for that tick, the byte
// request strobe, any received byte, and busy, done and error flags.
// Every bit on the bus spans four ticks; a transaction is start, address byte,
// ack, data bytes with their acks, then stop.
// The result is registered: result valid rises in the cycle after the tick is
// accepted, and one tick can be accepted every cycle while the result receiver
// takes its beats: the sequencer is a single pass of logic from the state register to the result register.
// If the result receiver stalls, the pending result is held and tick_ready
// drops until it is taken; no beat is lost.
// Reset returns the sequencer to idle with both lines released, empties the
// result register and sets device_address to 72 (address bytes 0x90/0x91).
// device_address sits at byte address 0 on the APB port.

module i2c_master_transaction import i2cmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        tick_valid,
  output logic        tick_ready,
  input  tick_t       tick,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);

  logic [6:0] device_address;
  state_t     state;
  state_t     state_next;
  result_t    result_next;
  logic       tick_fire;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEVICE_ADDRESS) ? {25'd0, device_address} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DEVICE_ADDRESS) begin
      device_address <= pwdata[6:0];
    end
  end

  i2cmt_core u_core (
    .device_address (device_address),
    .tick           (tick),
    .state          (state),
    .state_next     (state_next),
    .result         (result_next)
  );

  // output register frees up the same cycle its beat is taken
  assign tick_ready = !result_valid || result_ready;
  assign tick_fire = tick_valid && tick_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      result_valid <= 1'b0;
    end else begin
      if (tick_fire) begin
        state <= state_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  a_idle_tick_zero: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_IDLE |-> state.tick_in_bit == 2'd0)
    else $error("tick counter running while idle");

  a_read_inside_txn: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.read_valid |-> result.busy_res && !result.done_res)
    else $error("read byte outside a transaction body");

  a_request_on_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.byte_request |-> !state.is_read)
    else $error("byte request during a read");

  a_error_at_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error_code != ERR_NONE |-> result.done_res)
    else $error("error code outside the done beat");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    tick_fire && result_next.done_res |=> state.phase == PH_IDLE && !result.busy_res == 1'b0)
    else $error("sequencer not idle after done");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for i2c_master_transaction: drives bus ticks and APB writes,
// predicts every result beat in a scoreboard class and compares it field by field.
// Depends on i2cmt_pkg and the RTL of i2c_master_transaction.
`timescale 1ns / 1ps

module testbench;
  import i2cmt_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_TICKS = 750;

  typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_e;

  // what the emulated slave does during one transaction
  typedef struct {
    logic [1:0] mode;
    logic [7:0] len;
    bit         addr_nack;
    int         nack_left;
    fill_e      fill;
    bit         noisy;
  } plan_t;

  class bus_tick_scoreboard;
    logic [3:0] phase;
    logic [1:0] tick_pos;
    logic [2:0] bit_pos;
    logic [7:0] shifter;
    logic [7:0] remaining;
    logic       reading;
    logic [1:0] err_latched;
    logic [6:0] dev_addr;
    result_t    predicted_ticks[$];
    int         failures;

    function new();
      phase = PH_IDLE;
      tick_pos = '0;
      bit_pos = '0;
      shifter = '0;
      remaining = '0;
      reading = 1'b0;
      err_latched = ERR_NONE;
      dev_addr = DEVICE_ADDRESS_RESET;
      failures = 0;
    endfunction

    // advance the bus sequencer by one tick and queue the line levels it drives
    function void note_tick(tick_t t);
      result_t r;
      logic [7:0] len;
      bit last;
      r = '0;
      r.scl_level = 1'b1;
      r.sda_level = 1'b1;
      len = t.transfer_length;
      if (phase == PH_IDLE && (t.mode == MODE_WRITE || t.mode == MODE_READ)) begin
        reading = (t.mode == MODE_READ);
        if (reading && len == 8'd0) len = 8'd1;
        remaining = len;
        err_latched = ERR_NONE;
        tick_pos = '0;
        bit_pos = '0;
        phase = PH_START;
      end
      last = (tick_pos == 2'd3);
      case (phase)
        PH_START: begin
          r.scl_level = (tick_pos < 2'd2);
          r.sda_level = (tick_pos == 2'd0);
          if (last) begin
            shifter = {dev_addr, reading};
            bit_pos = '0;
            phase = PH_ADDR;
          end
        end
        PH_ADDR, PH_WDATA: begin
          if (phase == PH_WDATA && bit_pos == 3'd0 && tick_pos == 2'd0) begin
            shifter = t.write_byte;
            r.byte_request = 1'b1;
          end
          r.scl_level = (tick_pos == 2'd1);
          r.sda_level = shifter[3'd7 - bit_pos];
          if (last) begin
            if (bit_pos == 3'd7) begin
              bit_pos = '0;
              phase = (phase == PH_ADDR) ? PH_ADDR_ACK : PH_WACK;
            end else begin
              bit_pos = bit_pos + 3'd1;
            end
          end
        end
        PH_ADDR_ACK, PH_WACK: begin
          r.scl_level = (tick_pos == 2'd1);
          if (tick_pos == 2'd1 && t.sda_in)
            err_latched = (phase == PH_ADDR_ACK) ? ERR_ADDR : ERR_DATA;
          if (last) begin
            if (err_latched != ERR_NONE) begin
              phase = PH_STOP;
            end else if (phase == PH_ADDR_ACK) begin
              if (reading) phase = PH_RDATA;
              else phase = (remaining == 8'd0) ? PH_STOP : PH_WDATA;
            end else begin
              remaining = remaining - 8'd1;
              phase = (remaining == 8'd0) ? PH_STOP : PH_WDATA;
            end
            bit_pos = '0;
          end
        end
        PH_RDATA: begin
          r.scl_level = (tick_pos == 2'd1);
          if (tick_pos == 2'd1) shifter = {shifter[6:0], t.sda_in};
          if (last) begin
            if (bit_pos == 3'd7) begin
              r.read_byte = shifter;
              r.read_valid = 1'b1;
              bit_pos = '0;
              phase = PH_RACK;
            end else begin
              bit_pos = bit_pos + 3'd1;
            end
          end
        end
        PH_RACK: begin
          r.scl_level = (tick_pos == 2'd1);
          // ack every byte but the last
          r.sda_level = !(remaining > 8'd1);
          if (last) begin
            if (remaining != 8'd0) remaining = remaining - 8'd1;
            phase = (remaining == 8'd0) ? PH_STOP : PH_RDATA;
            bit_pos = '0;
          end
        end
        PH_STOP: begin
          r.scl_level = (tick_pos != 2'd0);
          r.sda_level = (tick_pos >= 2'd2);
          if (last) begin
            r.done_res = 1'b1;
            r.error_code = err_latched;
            r.busy_res = 1'b1;
            phase = PH_IDLE;
            bit_pos = '0;
          end
        end
        default: phase = PH_IDLE;
      endcase
      if (phase != PH_IDLE) r.busy_res = 1'b1;
      if (phase == PH_IDLE && !r.done_res) tick_pos = '0;
      else tick_pos = tick_pos + 2'd1;
      predicted_ticks.push_back(r);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (predicted_ticks.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %p", $time, got);
        failures++;
        return;
      end
      want = predicted_ticks.pop_front();
      compare("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      compare("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      compare("byte_request", 8'(want.byte_request), 8'(got.byte_request));
      compare("read_byte", want.read_byte, got.read_byte);
      compare("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      compare("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      compare("done_res", 8'(want.done_res), 8'(got.done_res));
      compare("error_code", 8'(want.error_code), 8'(got.error_code));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        tick_valid;
  logic        tick_ready;
  tick_t       tick;
  logic        result_valid;
  logic        result_ready;
  result_t     result;

  bus_tick_scoreboard sb = new();
  plan_t plans[$];
  plan_t cur;
  int tick_gap_pct;
  int ready_stall_pct;

  i2c_master_transaction DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .tick_valid(tick_valid),
    .tick_ready(tick_ready),
    .tick(tick),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic plan_t make_plan(logic [1:0] mode, logic [7:0] len, bit addr_nack = 0,
                                      int nack_left = 0, fill_e fill = FILL_RANDOM);
    plan_t p;
    p.mode = mode;
    p.len = len;
    p.addr_nack = addr_nack;
    p.nack_left = nack_left;
    p.fill = fill;
    p.noisy = 1'b0;
    return p;
  endfunction

  function automatic plan_t random_plan();
    plan_t p;
    int r;
    int sel;
    p = make_plan(MODE_TICK, 8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 8) begin
      p.mode = (r < 4) ? MODE_TICK : MODE_SPARE;
      return p;
    end
    p.mode = (r < 55) ? MODE_WRITE : MODE_READ;
    sel = $urandom_range(0, 9);
    if (p.mode == MODE_READ) begin
      p.len = 8'($urandom_range(0, 4));
    end else if (sel == 0) begin
      // long write cut short by a data nack
      p.len = 8'($urandom_range(9, 255));
      p.nack_left = int'(p.len) - int'($urandom_range(0, 2));
    end else begin
      p.len = 8'($urandom_range(0, 6));
      if (sel == 1 && p.len != 8'd0) p.nack_left = $urandom_range(1, int'(p.len));
    end
    p.addr_nack = ($urandom_range(0, 9) == 0);
    p.noisy = ($urandom_range(0, 19) == 0);
    sel = $urandom_range(0, 9);
    p.fill = (sel == 0) ? FILL_ZEROS : (sel == 1) ? FILL_ONES : FILL_RANDOM;
    return p;
  endfunction

  // next tick, shaped by where the sequencer stands after the ticks already accepted
  function automatic tick_t next_tick();
    tick_t t;
    t.mode = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : MODE_TICK;
    t.transfer_length = 8'($urandom);
    t.sda_in = 1'($urandom);
    if (sb.phase == PH_IDLE) begin
      cur = (plans.size() != 0) ? plans.pop_front() : random_plan();
      t.mode = cur.mode;
      t.transfer_length = cur.len;
    end else if (!cur.noisy && sb.tick_pos == 2'd1) begin
      case (sb.phase)
        PH_ADDR_ACK: t.sda_in = cur.addr_nack;
        PH_WACK: t.sda_in = (int'(sb.remaining) == cur.nack_left);
        PH_RDATA: if (cur.fill != FILL_RANDOM) t.sda_in = (cur.fill == FILL_ONES);
        default: ;
      endcase
    end
    case (cur.fill)
      FILL_ZEROS: t.write_byte = 8'h00;
      FILL_ONES: t.write_byte = 8'hFF;
      default: t.write_byte = 8'($urandom);
    endcase
    return t;
  endfunction

  function automatic int gap_len(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 50;
    endcase
  endfunction

  task automatic send_ticks(int count);
    int sent;
    int gap;
    tick_t nxt;
    sent = 0;
    while (sent < count || plans.size() != 0 || sb.phase != PH_IDLE) begin
      if (sent % 150 == 0) begin
        tick_gap_pct = pick_pct();
        ready_stall_pct = pick_pct();
      end
      gap = gap_len(tick_gap_pct);
      if (gap != 0) begin
        tick_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      nxt = next_tick();
      tick <= nxt;
      tick_valid <= 1'b1;
      do @(posedge clk); while (!tick_ready);
      sb.note_tick(nxt);
      sent++;
    end
    tick_valid <= 1'b0;
  endtask

  task automatic write_device_address(logic [6:0] value);
    logic [31:0] word;
    word = $urandom;
    word[6:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(REG_DEVICE_ADDRESS) << 2;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.dev_addr = value;
  endtask

  task automatic drain();
    while (sb.predicted_ticks.size() != 0) @(posedge clk);
  endtask

  // result side: check each beat taken, stall at random
  initial begin : receiver
    int hold;
    hold = 0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) sb.check_result(result);
      if (hold != 0) begin
        hold--;
        result_ready <= 1'b0;
      end else begin
        hold = gap_len(ready_stall_pct);
        result_ready <= (hold == 0);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((tick_valid && tick_ready) || (result_valid && result_ready) || psel || rst) quiet = 0;
      else quiet++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : main
    logic [6:0] addr_settings[5];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_valid = 1'b0;
    tick = '0;
    tick_gap_pct = 0;
    ready_stall_pct = 0;
    addr_settings[0] = 7'h7F;
    addr_settings[1] = 7'h00;
    for (int i = 2; i < 5; i++) addr_settings[i] = 7'($urandom);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed transactions at the reset address
    plans.push_back(make_plan(MODE_TICK, 8'hFF));
    plans.push_back(make_plan(MODE_SPARE, 8'h05));
    plans.push_back(make_plan(MODE_WRITE, 8'd0));
    plans.push_back(make_plan(MODE_WRITE, 8'd1, 0, 0, FILL_ONES));
    plans.push_back(make_plan(MODE_WRITE, 8'd2, 0, 0, FILL_ZEROS));
    plans.push_back(make_plan(MODE_WRITE, 8'd3, 1));
    plans.push_back(make_plan(MODE_WRITE, 8'd255, 0, 254));
    plans.push_back(make_plan(MODE_WRITE, 8'd2, 0, 1));
    plans.push_back(make_plan(MODE_READ, 8'd0, 0, 0, FILL_ONES));
    plans.push_back(make_plan(MODE_READ, 8'd2, 0, 0, FILL_ZEROS));
    plans.push_back(make_plan(MODE_READ, 8'd3));
    plans.push_back(make_plan(MODE_READ, 8'd1, 1));
    send_ticks(0);

    foreach (addr_settings[i]) begin
      drain();
      @(posedge clk);
      write_device_address(addr_settings[i]);
      send_ticks(RANDOM_TICKS / 5);
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.failures == 0 && sb.predicted_ticks.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
